>>> hdl/bcsc_pkg.sv
package bcsc_pkg;

	localparam int CHANNELS_DEF = 2;
	localparam int MODE_HOLD_DEF = 10;

	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int FLOAT_MARGIN = 70;
	localparam int DWELL_FLOOR = 10;
	localparam int DWELL_STEP = 2;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;

	typedef enum logic [1:0] {
		FN_INIT  = 2'd0,
		FN_STAGE = 2'd1,
		FN_MODE  = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_PRE   = 2'd0,
		ST_CHG   = 2'd1,
		ST_FLT   = 2'd2,
		ST_FAULT = 2'd3
	} stage_t;

	typedef enum logic [2:0] {
		REG_CUTOFF_V    = 3'd0,
		REG_CHARGING_V  = 3'd1,
		REG_FLOATING_V  = 3'd2,
		REG_PRE_I_LIMIT = 3'd3,
		REG_BULK_I      = 3'd4,
		REG_FLOAT_I     = 3'd5,
		REG_PRE_TICKS   = 3'd6,
		REG_LOW_I_TICKS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [14:0] v_cutoff;
		logic [14:0] v_charge;
		logic [14:0] v_float;
		logic [14:0] precharge_current_limit;
		logic [14:0] bulk_current_limit;
		logic [14:0] float_current;
		logic [14:0] precharge_ticks;
		logic [15:0] low_current_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		v_cutoff:                15'd2000,
		v_charge:                15'd2880,
		v_float:                 15'd2720,
		precharge_current_limit: 15'd100,
		bulk_current_limit:      15'd1000,
		float_current:           15'd50,
		precharge_ticks:         15'd300,
		low_current_ticks:       16'd600
	};

	typedef struct packed {
		stage_t             stage;
		logic [14:0]        timer;
		logic [15:0]        dwell;
		logic signed [7:0]  hold;
		logic [7:0]         delay;
		logic               cc;
		logic [14:0]        vref;
		logic [14:0]        iref;
	} chan_entry_t;

endpackage

>>> hdl/bcsc_cfg_regs.sv
module bcsc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [bcsc_pkg::REG_IDX_W-1:0]      index,
	input  logic [bcsc_pkg::CFG_DATA_W-1:0]     data,
	output bcsc_pkg::cfg_t                      cfg
);
	import bcsc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (we) begin
			unique case (cfg_reg_t'(index))
				REG_CUTOFF_V:    cfg_q.v_cutoff <= data[14:0];
				REG_CHARGING_V:  cfg_q.v_charge <= data[14:0];
				REG_FLOATING_V:  cfg_q.v_float <= data[14:0];
				REG_PRE_I_LIMIT: cfg_q.precharge_current_limit <= data[14:0];
				REG_BULK_I:      cfg_q.bulk_current_limit <= data[14:0];
				REG_FLOAT_I:     cfg_q.float_current <= data[14:0];
				REG_PRE_TICKS:   cfg_q.precharge_ticks <= data[14:0];
				REG_LOW_I_TICKS: cfg_q.low_current_ticks <= data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/bcsc_state_mem.sv
module bcsc_state_mem #(
	parameter int DEPTH = bcsc_pkg::CHANNELS_DEF,
	parameter int AW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output bcsc_pkg::chan_entry_t  rd_data,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  bcsc_pkg::chan_entry_t  wr_data
);
	import bcsc_pkg::*;

	chan_entry_t mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	chan_entry_t rd_data_q;
	chan_entry_t fwd_data_q;
	logic rd_valid_q;
	logic fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A write to the entry being read in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				fwd_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_comb begin
		if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (rd_valid_q) begin
			rd_data = rd_data_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

>>> hdl/bcsc_update.sv
module bcsc_update #(
	parameter int MODE_HOLD = bcsc_pkg::MODE_HOLD_DEF
) (
	input  logic [1:0]             func,
	input  logic signed [15:0]     meas_voltage,
	input  logic signed [15:0]     meas_current,
	input  bcsc_pkg::cfg_t         cfg,
	input  bcsc_pkg::chan_entry_t  cur,
	output bcsc_pkg::chan_entry_t  nxt
);
	import bcsc_pkg::*;

	localparam logic signed [7:0] HB_MAX = 8'(MODE_HOLD);
	localparam logic signed [7:0] HB_MIN = -HB_MAX;
	localparam logic [7:0] REENTRY_DELAY = 8'(2 * MODE_HOLD);

	logic signed [16:0] v_ext;
	logic signed [16:0] i_ext;
	logic signed [16:0] float_thr;
	logic [15:0] dwell_dec;
	logic signed [7:0] hold_inc1;
	logic signed [7:0] hold_inc2;
	logic signed [7:0] hold_dec;

	assign v_ext = {meas_voltage[15], meas_voltage};
	assign i_ext = {meas_current[15], meas_current};
	assign float_thr = $signed({2'b00, cfg.v_float}) - 17'(FLOAT_MARGIN);
	assign dwell_dec = cur.dwell - 16'(DWELL_STEP);
	assign hold_inc1 = (cur.hold < HB_MAX) ? cur.hold + 8'sd1 : cur.hold;
	assign hold_inc2 = (hold_inc1 < HB_MAX) ? hold_inc1 + 8'sd1 : hold_inc1;
	assign hold_dec = cur.hold - 8'sd1;

	always_comb begin
		nxt = cur;
		case (func_t'(func))
			FN_INIT: begin
				nxt.stage = ST_PRE;
				nxt.timer = cfg.precharge_ticks;
				nxt.iref = cfg.precharge_current_limit;
				nxt.vref = cfg.v_charge;
				nxt.dwell = cfg.low_current_ticks;
			end
			FN_STAGE: begin
				unique case (cur.stage)
					ST_PRE: begin
						if (v_ext < $signed({2'b00, cfg.v_cutoff})) begin
							if (cur.timer != '0) begin
								nxt.timer = cur.timer - 15'd1;
							end else begin
								nxt.stage = ST_FAULT;
							end
						end else begin
							nxt.stage = ST_CHG;
							nxt.iref = cfg.bulk_current_limit;
						end
					end
					ST_CHG: begin
						nxt.vref = cfg.v_charge;
						if (!cur.cc && (i_ext < $signed({2'b00, cfg.float_current}))) begin
							if (dwell_dec < 16'(DWELL_FLOOR)) begin
								nxt.stage = ST_FLT;
								nxt.dwell = 16'(DWELL_FLOOR);
							end else begin
								nxt.dwell = dwell_dec;
							end
						end else if (cur.dwell < cfg.low_current_ticks) begin
							nxt.dwell = cur.dwell + 16'd1;
						end
					end
					ST_FLT: begin
						nxt.vref = cfg.v_float;
						nxt.iref = cfg.float_current;
						nxt.cc = 1'b0;
					end
					ST_FAULT: begin
						nxt.stage = ST_PRE;
					end
					default: begin
						nxt.stage = ST_PRE;
					end
				endcase
			end
			FN_MODE: begin
				if (v_ext >= $signed({2'b00, cur.vref})) begin
					nxt.hold = hold_inc2;
					if (cur.delay != '0) begin
						nxt.delay = cur.delay - 8'd1;
					end else begin
						nxt.cc = 1'b0;
					end
				end else if (hold_dec < HB_MIN) begin
					nxt.cc = 1'b1;
					nxt.delay = REENTRY_DELAY;
					nxt.hold = HB_MIN;
				end else begin
					nxt.hold = hold_dec;
				end
				if ((i_ext > $signed({2'b00, cur.iref})) && !nxt.cc &&
				    (cur.stage == ST_FLT) && (v_ext < float_thr)) begin
					nxt.stage = ST_CHG;
					nxt.vref = cfg.v_charge;
					nxt.iref = cfg.bulk_current_limit;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> hdl/battery_charge_stage_controller.sv
// Each item passes the update stage, then the output register, before it is offered.
// Throughput: one item per cycle unless m_tready stalls the output, including back-to-back
// items on the same channel, which see the previous write through a forwarding path in the
// channel state memory. The per-channel state lives in one memory read in the transfer cycle
// and written back as the item leaves the update stage. Reset makes all entries read zero.
module battery_charge_stage_controller #(
	parameter int CHANNELS = bcsc_pkg::CHANNELS_DEF,
	parameter int MODE_HOLD = bcsc_pkg::MODE_HOLD_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// channel, meas_voltage, meas_current
	input  logic [bcsc_pkg::S_TDATA_W-1:0]       s_tdata,
	// func
	input  logic [bcsc_pkg::S_TUSER_W-1:0]       s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_channel, stage, voltage_setpoint, current_setpoint, cc_mode
	output logic [bcsc_pkg::M_TDATA_W-1:0]       m_tdata,
	input  logic                                 cfg_we,
	input  logic [bcsc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [bcsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bcsc_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t cfg;
	chan_entry_t rd_entry;
	chan_entry_t nxt_entry;

	logic in_xfer;
	logic s1_adv;
	logic [AW-1:0] in_addr;

	logic s1_v;
	logic [1:0] func_s1;
	logic ch_s1;
	logic [AW-1:0] addr_s1;
	logic signed [15:0] v_s1;
	logic signed [15:0] i_s1;

	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign s1_adv = !m_tvalid_q || m_tready;
	assign s_tready = !s1_v || s1_adv;
	assign in_xfer = s_tvalid && s_tready;
	assign in_addr = (CHANNELS > 1) ? AW'(s_tdata[0]) : '0;

	bcsc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	bcsc_state_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.rd_addr (in_addr),
		.rd_data (rd_entry),
		.wr_en   (s1_v && s1_adv),
		.wr_addr (addr_s1),
		.wr_data (nxt_entry)
	);

	bcsc_update #(
		.MODE_HOLD (MODE_HOLD)
	) u_update (
		.func         (func_s1),
		.meas_voltage (v_s1),
		.meas_current (i_s1),
		.cfg          (cfg),
		.cur          (rd_entry),
		.nxt          (nxt_entry)
	);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1 <= s_tuser[1:0];
			ch_s1 <= s_tdata[0];
			addr_s1 <= in_addr;
			v_s1 <= s_tdata[16:1];
			i_s1 <= s_tdata[32:17];
		end
		if (s1_v && s1_adv) begin
			m_tdata_q <= {6'd0, nxt_entry.cc, nxt_entry.iref, nxt_entry.vref,
				nxt_entry.stage, ch_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_v <= s_tvalid;
			end
			if (s1_adv) begin
				m_tvalid_q <= s1_v;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_xfer_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> s1_v)
		else $error("transfer did not reach the update stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !s1_adv) |=> (s1_v && $stable(ch_s1) && $stable(func_s1)))
		else $error("stalled update stage lost its item");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && s1_adv) |=> m_tvalid)
		else $error("updated item did not reach the output register");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_v && m_tvalid && !m_tready))
		else $error("input stalled without a full pipeline");

endmodule
